[rtl/core/motor_gear_duty_controller_assert.svh]
// Assertion macros for the motor gear duty controller.
// Included by the RTL files that carry concurrent assertions.
`ifndef MOTOR_GEAR_DUTY_CONTROLLER_ASSERT_SVH
`define MOTOR_GEAR_DUTY_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property at every rising clock edge, disabled while reset is asserted.
`define MGDC_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property at every rising clock edge, also during reset.
`define MGDC_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MGDC_ASSERT_RST(label, clk, rst_n, prop, msg)
`define MGDC_ASSERT(label, clk, prop, msg)
`endif

`endif

[rtl/core/mgdc_pkg.sv]
// Shared types, codes and helpers for the motor gear duty controller.
// No dependencies; used by mgdc_step and motor_gear_duty_controller.
`timescale 1ns / 1ps

package mgdc_pkg;

  localparam int unsigned DutyW   = 7;
  localparam int unsigned GearW   = 3;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned KeyW    = 4;
  localparam int unsigned NumGears = 5;

  typedef logic [DutyW-1:0]   duty_t;
  typedef logic [GearW-1:0]   gear_t;
  typedef logic [TicksW-1:0]  ticks_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [KeyW-1:0]    key_t;

  localparam duty_t  DutyMax   = duty_t'(100);
  localparam ticks_t CountMax  = ticks_t'(16'hFFFF);

  // Key codes
  localparam key_t KeyA = key_t'(10);
  localparam key_t KeyB = key_t'(11);
  localparam key_t KeyC = key_t'(12);
  localparam key_t KeyD = key_t'(13);
  localparam key_t KeyGearLo = key_t'(1);
  localparam key_t KeyGearHi = key_t'(5);

  // Result status codes
  localparam status_t StSettled = status_t'(0);
  localparam status_t StRamp    = status_t'(1);
  localparam status_t StBrake   = status_t'(2);
  localparam status_t StBad     = status_t'(3);
  localparam status_t StInvalid = status_t'(4);

  // Input mode codes
  localparam logic ModeKey  = 1'b0;
  localparam logic ModeTick = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CfgGear1 = cfg_idx_t'(0);
  localparam cfg_idx_t CfgGear2 = cfg_idx_t'(1);
  localparam cfg_idx_t CfgGear3 = cfg_idx_t'(2);
  localparam cfg_idx_t CfgGear4 = cfg_idx_t'(3);
  localparam cfg_idx_t CfgGear5 = cfg_idx_t'(4);
  localparam cfg_idx_t CfgEco   = cfg_idx_t'(5);
  localparam cfg_idx_t CfgBrake = cfg_idx_t'(6);

  // Configuration reset values
  localparam duty_t  RstGear1 = duty_t'(20);
  localparam duty_t  RstGear2 = duty_t'(25);
  localparam duty_t  RstGear3 = duty_t'(30);
  localparam duty_t  RstGear4 = duty_t'(40);
  localparam duty_t  RstGear5 = duty_t'(50);
  localparam ticks_t RstEco   = ticks_t'(50);
  localparam ticks_t RstBrake = ticks_t'(10);
  localparam gear_t  GearOne  = gear_t'(1);

  typedef struct packed {
    duty_t [NumGears-1:0] gear_duty;
    ticks_t               eco_ticks;
    ticks_t               brake_ticks;
  } cfg_t;

  typedef struct packed {
    duty_t  present;
    duty_t  target;
    gear_t  gear;
    logic   sport;
    logic   braking;
    ticks_t count;
  } state_t;

  typedef struct packed {
    status_t status;
    logic    sport;
    gear_t   gear;
    duty_t   duty;
  } result_t;

  // Clamp a gear duty register to the legal percent range.
  function automatic duty_t sat_duty(duty_t v);
    return (v > DutyMax) ? DutyMax : v;
  endfunction

endpackage

[rtl/core/mgdc_step.sv]
// Next-state and result logic for one key event or tick.
// Depends on mgdc_pkg.
`timescale 1ns / 1ps

module mgdc_step (
  input  mgdc_pkg::cfg_t    cfg_i,
  input  mgdc_pkg::state_t  state_i,
  input  logic              mode_i,
  input  mgdc_pkg::key_t    key_i,
  output mgdc_pkg::state_t  state_o,
  output mgdc_pkg::result_t result_o
);

  // Count one tick toward an interval; a zero interval counts as one.
  typedef struct packed {
    logic              done;
    mgdc_pkg::ticks_t  count;
  } ivl_t;

  function automatic ivl_t interval(mgdc_pkg::ticks_t cnt, mgdc_pkg::ticks_t ticks);
    mgdc_pkg::ticks_t lim;
    mgdc_pkg::ticks_t inc;
    ivl_t r;
    lim = (ticks == '0) ? mgdc_pkg::ticks_t'(1) : ticks;
    inc = (cnt < mgdc_pkg::CountMax) ? cnt + mgdc_pkg::ticks_t'(1) : cnt;
    r.done  = (inc >= lim);
    r.count = r.done ? '0 : inc;
    return r;
  endfunction

  ivl_t             brake_ivl;
  ivl_t             eco_ivl;
  mgdc_pkg::state_t nxt;
  mgdc_pkg::status_t st;
  mgdc_pkg::duty_t  gear_key_duty;
  mgdc_pkg::gear_t  key_gear;
  logic             key_is_gear;
  logic             shift_bad;

  assign brake_ivl = interval(state_i.count, cfg_i.brake_ticks);
  assign eco_ivl   = interval(state_i.count, cfg_i.eco_ticks);

  // Gear key decode and the one-gear shift limit
  assign key_gear    = key_i[mgdc_pkg::GearW-1:0];
  assign key_is_gear = (key_i >= mgdc_pkg::KeyGearLo) && (key_i <= mgdc_pkg::KeyGearHi);
  assign shift_bad   = (key_gear > state_i.gear) ? (key_gear - state_i.gear > mgdc_pkg::gear_t'(1))
                                                 : (state_i.gear - key_gear > mgdc_pkg::gear_t'(1));
  assign gear_key_duty = key_is_gear
      ? mgdc_pkg::sat_duty(cfg_i.gear_duty[key_gear - mgdc_pkg::gear_t'(1)])
      : '0;

  // Apply one tick or one key to the state
  always_comb begin
    nxt = state_i;
    st  = mgdc_pkg::StSettled;
    if (mode_i == mgdc_pkg::ModeTick) begin
      if (state_i.braking) begin
        nxt.count = brake_ivl.count;
        if (brake_ivl.done && (state_i.present != '0)) begin
          nxt.present = state_i.present - mgdc_pkg::duty_t'(1);
        end
        if (nxt.present == '0) begin
          nxt.braking = 1'b0;
          nxt.count   = '0;
        end
      end else if (state_i.present != state_i.target) begin
        if (state_i.sport) begin
          nxt.present = state_i.target;
          nxt.count   = '0;
        end else begin
          nxt.count = eco_ivl.count;
          if (eco_ivl.done) begin
            nxt.present = (state_i.present > state_i.target)
                        ? state_i.present - mgdc_pkg::duty_t'(1)
                        : state_i.present + mgdc_pkg::duty_t'(1);
          end
        end
      end else begin
        nxt.count = '0;
      end
    end else begin
      priority if (key_i == mgdc_pkg::KeyA) begin
        nxt.sport = 1'b0;
      end else if (key_i == mgdc_pkg::KeyB) begin
        nxt.sport = 1'b1;
        if (!state_i.braking) begin
          nxt.present = state_i.target;
          nxt.count   = '0;
        end
      end else if (key_i == mgdc_pkg::KeyC) begin
        nxt.gear    = mgdc_pkg::GearOne;
        nxt.target  = '0;
        nxt.count   = '0;
        nxt.braking = (state_i.present != '0);
      end else if (key_i == mgdc_pkg::KeyD) begin
        nxt.gear    = mgdc_pkg::GearOne;
        nxt.target  = mgdc_pkg::sat_duty(cfg_i.gear_duty[0]);
        nxt.present = mgdc_pkg::sat_duty(cfg_i.gear_duty[0]);
        nxt.braking = 1'b0;
        nxt.count   = '0;
      end else if (key_is_gear) begin
        if (shift_bad) begin
          st = mgdc_pkg::StBad;
        end else begin
          nxt.gear    = key_gear;
          nxt.target  = gear_key_duty;
          nxt.braking = 1'b0;
          nxt.count   = '0;
          if (state_i.sport) begin
            nxt.present = gear_key_duty;
          end
        end
      end else begin
        st = mgdc_pkg::StInvalid;
      end
    end
    // Report brake or ramp progress when nothing was rejected
    if (st == mgdc_pkg::StSettled) begin
      if (nxt.braking) begin
        st = mgdc_pkg::StBrake;
      end else if (nxt.present != nxt.target) begin
        st = mgdc_pkg::StRamp;
      end
    end
  end

  assign state_o         = nxt;
  assign result_o.status = st;
  assign result_o.sport  = nxt.sport;
  assign result_o.gear   = nxt.gear;
  assign result_o.duty   = nxt.present;

endmodule

[rtl/core/motor_gear_duty_controller.sv]
// Top level of the motor gear duty controller: config registers, state,
// result register and stream handshake. Depends on mgdc_pkg, mgdc_step.
//
//   Port group   Dir  Contents
//   s_axis       in   tdata: key[3:0]; tuser: mode (0 key, 1 tick)
//   m_axis       out  tdata: duty[6:0] gear[9:7] sport[10] status[13:11]
//   cfg          in   cfg_we_i / cfg_idx_i / cfg_data_i, write only
//
// One item per cycle: the state update for an item is one combinational
// pass from the state registers into the state and the result register.
// An item is taken whenever the result register is empty or drained in the
// same cycle, so a stalled output holds the input off after one item.
// Reset loads the register defaults, duty 0, gear 1, eco mode, not braking.
`timescale 1ns / 1ps
`include "motor_gear_duty_controller_assert.svh"

module motor_gear_duty_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] key, [7:4] zero
  input  logic        s_axis_tuser,   // [0] mode
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] duty, [9:7] gear, [10] sport,
                                      // [13:11] status, [15:14] zero
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  mgdc_pkg::cfg_t    cfg_q;
  mgdc_pkg::state_t  state_q, state_d;
  mgdc_pkg::result_t res_d, res_q;
  logic              out_valid_q;
  logic              in_fire;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gear_duty[0] <= mgdc_pkg::RstGear1;
      cfg_q.gear_duty[1] <= mgdc_pkg::RstGear2;
      cfg_q.gear_duty[2] <= mgdc_pkg::RstGear3;
      cfg_q.gear_duty[3] <= mgdc_pkg::RstGear4;
      cfg_q.gear_duty[4] <= mgdc_pkg::RstGear5;
      cfg_q.eco_ticks    <= mgdc_pkg::RstEco;
      cfg_q.brake_ticks  <= mgdc_pkg::RstBrake;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mgdc_pkg::CfgGear1: cfg_q.gear_duty[0] <= cfg_data_i[mgdc_pkg::DutyW-1:0];
        mgdc_pkg::CfgGear2: cfg_q.gear_duty[1] <= cfg_data_i[mgdc_pkg::DutyW-1:0];
        mgdc_pkg::CfgGear3: cfg_q.gear_duty[2] <= cfg_data_i[mgdc_pkg::DutyW-1:0];
        mgdc_pkg::CfgGear4: cfg_q.gear_duty[3] <= cfg_data_i[mgdc_pkg::DutyW-1:0];
        mgdc_pkg::CfgGear5: cfg_q.gear_duty[4] <= cfg_data_i[mgdc_pkg::DutyW-1:0];
        mgdc_pkg::CfgEco:   cfg_q.eco_ticks    <= cfg_data_i;
        mgdc_pkg::CfgBrake: cfg_q.brake_ticks  <= cfg_data_i;
        default: ; // unused index: drop the write
      endcase
    end
  end

  // Accept while the result register is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  mgdc_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .mode_i   (s_axis_tuser),
    .key_i    (s_axis_tdata[mgdc_pkg::KeyW-1:0]),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Advance the controller state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.present <= '0;
      state_q.target  <= '0;
      state_q.gear    <= mgdc_pkg::GearOne;
      state_q.sport   <= 1'b0;
      state_q.braking <= 1'b0;
      state_q.count   <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded with each accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q};

  `MGDC_ASSERT_RST(a_gear_range, clk_i, rst_ni,
    (state_q.gear != '0) && (state_q.gear <= mgdc_pkg::gear_t'(mgdc_pkg::NumGears)),
    "gear left the range one to five")
  `MGDC_ASSERT_RST(a_brake_target, clk_i, rst_ni,
    state_q.braking |-> (state_q.target == '0),
    "braking with a nonzero target duty")
  `MGDC_ASSERT_RST(a_duty_max, clk_i, rst_ni,
    (state_q.present <= mgdc_pkg::DutyMax) && (state_q.target <= mgdc_pkg::DutyMax),
    "duty above one hundred percent")
  `MGDC_ASSERT_RST(a_stall_blocks, clk_i, rst_ni,
    (out_valid_q && !m_axis_tready) |-> !s_axis_tready,
    "input taken while result is stalled")
  `MGDC_ASSERT_RST(a_fire_result, clk_i, rst_ni,
    in_fire |=> out_valid_q,
    "accepted item produced no result")

endmodule
